/* hdl/kmm_pkg.sv */
// ----------------------------------------------------------------------------
// kmm_pkg
// Shared constants, types and state codes for the Kruskal spanning tree block.
// ----------------------------------------------------------------------------
package kmm_pkg;

    localparam int VTX_LIMIT    = 16;
    localparam int VTX_W        = (VTX_LIMIT > 1) ? $clog2(VTX_LIMIT) : 1;
    localparam int CNT_W        = $clog2(VTX_LIMIT + 1);
    localparam int TOT_W        = 2 * CNT_W;
    localparam int MAT_DEPTH    = VTX_LIMIT * VTX_LIMIT;
    localparam int ADDR_W       = $clog2(MAT_DEPTH);

    localparam int COST_W       = 16;
    localparam int CFG_W        = 5;
    localparam int VFIELD_W     = 4;
    localparam int CHOSEN_W     = 14;
    localparam int SUM_W        = 18;

    localparam logic [COST_W-1:0] NO_EDGE = COST_W'(9999);

    typedef struct packed {
        logic                edge_valid;
        logic [VFIELD_W-1:0] vertex_a;
        logic [VFIELD_W-1:0] vertex_b;
        logic [CHOSEN_W-1:0] chosen_cost;
        logic [SUM_W-1:0]    total_cost;
        logic                spanning;
        logic                last;
    } res_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_ROW,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_MARK_A,
        ST_MARK_B,
        ST_RELABEL,
        ST_RDRAIN,
        ST_EMIT
    } state_t;

    // What the item in the evaluation stage is.
    typedef enum logic [1:0] {
        P_NONE,
        P_HEAD,
        P_ELEM,
        P_RELAB
    } pkind_t;

endpackage

/* hdl/kmm_ifs.sv */
// ----------------------------------------------------------------------------
// kmm_ifs
// Valid/ready channels of the block: cost entries, configuration, results.
// ----------------------------------------------------------------------------
interface kmm_cost_if;
    logic                      valid;
    logic                      ready;
    logic [kmm_pkg::COST_W-1:0] edge_cost;

    modport source (output valid, output edge_cost, input ready);
    modport sink   (input valid, input edge_cost, output ready);
endinterface

interface kmm_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [kmm_pkg::CFG_W-1:0] vertex_count;

    modport source (output valid, output vertex_count, input ready);
    modport sink   (input valid, input vertex_count, output ready);
endinterface

interface kmm_result_if;
    logic                        valid;
    logic                        ready;
    logic                        edge_valid;
    logic [kmm_pkg::VFIELD_W-1:0] vertex_a;
    logic [kmm_pkg::VFIELD_W-1:0] vertex_b;
    logic [kmm_pkg::CHOSEN_W-1:0] chosen_cost;
    logic [kmm_pkg::SUM_W-1:0]    total_cost;
    logic                        spanning;
    logic                        last;

    modport source (output valid, output edge_valid, output vertex_a, output vertex_b,
                    output chosen_cost, output total_cost, output spanning,
                    output last, input ready);
    modport sink   (input valid, input edge_valid, input vertex_a, input vertex_b,
                    input chosen_cost, input total_cost, input spanning,
                    input last, output ready);
endinterface

/* hdl/kmm_ram.sv */
// ----------------------------------------------------------------------------
// kmm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kmm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/kmm_ctrl.sv */
// ----------------------------------------------------------------------------
// kmm_ctrl
// Loads the cost matrix and runs the Kruskal passes over the two memories.
// ----------------------------------------------------------------------------
module kmm_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [kmm_pkg::CNT_W-1:0]  n,
    input  logic                       in_valid,
    input  logic [kmm_pkg::COST_W-1:0] in_cost,
    output logic                       in_ready,
    output logic                       emit_valid,
    input  logic                       emit_ready,
    output kmm_pkg::res_t              emit_res
);
    import kmm_pkg::*;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  load_pos_reg, load_pos_next;
    logic [VTX_W-1:0]   i_reg, i_next;
    logic [VTX_W-1:0]   j_reg, j_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;

    pkind_t             pk_reg, pk_next;
    logic [VTX_W-1:0]   pi_reg, pi_next;
    logic [VTX_W-1:0]   pj_reg, pj_next;
    logic [ADDR_W-1:0]  paddr_reg, paddr_next;

    logic [VTX_W-1:0]   ri_reg, ri_next;
    logic [COST_W-1:0]  best_reg, best_next;
    logic [VTX_W-1:0]   ba_reg, ba_next;
    logic [VTX_W-1:0]   bb_reg, bb_next;
    logic [ADDR_W-1:0]  baddr_reg, baddr_next;
    logic [VTX_W-1:0]   bra_reg, bra_next;
    logic [VTX_W-1:0]   brb_reg, brb_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   edges_reg, edges_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    res_t               res_reg, res_next;

    logic               mat_we;
    logic [ADDR_W-1:0]  mat_waddr;
    logic [COST_W-1:0]  mat_wdata;
    logic [ADDR_W-1:0]  mat_raddr;
    logic [COST_W-1:0]  mat_rdata;
    logic               lbl_we;
    logic [VTX_W-1:0]   lbl_waddr;
    logic [VTX_W-1:0]   lbl_wdata;
    logic [VTX_W-1:0]   lbl_raddr;
    logic [VTX_W-1:0]   lbl_rdata;

    logic [CNT_W-1:0]   n_last;
    logic [TOT_W-1:0]   total;
    logic [TOT_W-1:0]   pos_wide;
    logic [TOT_W-1:0]   mirror_wide;
    logic               j_end;
    logic               i_end;
    logic               fin;

    kmm_ram #(.DEPTH(MAT_DEPTH), .WIDTH(COST_W)) u_mat (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    // Set label of every vertex: one label per component, rewritten over all vertices when two components merge.
    kmm_ram #(.DEPTH(VTX_LIMIT), .WIDTH(VTX_W)) u_lbl (
        .clk   (clk),
        .we    (lbl_we),
        .waddr (lbl_waddr),
        .wdata (lbl_wdata),
        .raddr (lbl_raddr),
        .rdata (lbl_rdata)
    );

    assign n_last      = n - CNT_W'(1);
    assign total       = TOT_W'(n) * TOT_W'(n);
    assign pos_wide    = TOT_W'(load_pos_reg);
    assign mirror_wide = TOT_W'(bb_reg) * TOT_W'(n) + TOT_W'(ba_reg);
    assign j_end       = (CNT_W'(j_reg) == n_last);
    assign i_end       = (CNT_W'(i_reg) == n_last);
    assign fin         = (edges_reg == n_last);
    assign emit_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_pos_reg <= '0;
            pk_reg       <= P_NONE;
            found_reg    <= 1'b0;
            edges_reg    <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_pos_reg <= load_pos_next;
            pk_reg       <= pk_next;
            found_reg    <= found_next;
            edges_reg    <= edges_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        addr_reg  <= addr_next;
        pi_reg    <= pi_next;
        pj_reg    <= pj_next;
        paddr_reg <= paddr_next;
        ri_reg    <= ri_next;
        best_reg  <= best_next;
        ba_reg    <= ba_next;
        bb_reg    <= bb_next;
        baddr_reg <= baddr_next;
        bra_reg   <= bra_next;
        brb_reg   <= brb_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        load_pos_next = load_pos_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        addr_next     = addr_reg;
        pk_next       = P_NONE;
        pi_next       = i_reg;
        pj_next       = j_reg;
        paddr_next    = addr_reg;
        ri_next       = ri_reg;
        best_next     = best_reg;
        ba_next       = ba_reg;
        bb_next       = bb_reg;
        baddr_next    = baddr_reg;
        bra_next      = bra_reg;
        brb_next      = brb_reg;
        found_next    = found_reg;
        edges_next    = edges_reg;
        sum_next      = sum_reg;
        res_next      = res_reg;

        in_ready   = 1'b0;
        emit_valid = 1'b0;
        mat_we     = 1'b0;
        mat_waddr  = load_pos_reg;
        mat_wdata  = in_cost;
        mat_raddr  = addr_reg;
        lbl_we     = 1'b0;
        lbl_waddr  = j_reg;
        lbl_wdata  = j_reg;
        lbl_raddr  = j_reg;

        // Evaluation stage: memory data of the item issued last cycle.
        unique case (pk_reg)
            P_HEAD:
            begin
                ri_next = lbl_rdata;
            end
            P_ELEM:
            begin
                if ((lbl_rdata != ri_reg) && (mat_rdata < best_reg))
                begin
                    best_next  = mat_rdata;
                    ba_next    = pi_reg;
                    bb_next    = pj_reg;
                    baddr_next = paddr_reg;
                    bra_next   = ri_reg;
                    brb_next   = lbl_rdata;
                    found_next = 1'b1;
                end
            end
            P_RELAB:
            begin
                if (lbl_rdata == bra_reg)
                begin
                    lbl_we    = 1'b1;
                    lbl_waddr = pj_reg;
                    lbl_wdata = brb_reg;
                end
            end
            default:
            begin
            end
        endcase

        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (pos_wide < total)
                    begin
                        mat_we = 1'b1;
                    end
                    if (pos_wide + TOT_W'(1) >= total)
                    begin
                        load_pos_next = '0;
                        j_next        = '0;
                        edges_next    = '0;
                        sum_next      = '0;
                        state_next    = ST_INIT;
                    end
                    else
                    begin
                        load_pos_next = load_pos_reg + ADDR_W'(1);
                    end
                end
            end
            ST_INIT:
            begin
                lbl_we    = 1'b1;
                lbl_waddr = j_reg;
                lbl_wdata = j_reg;
                if (j_end)
                begin
                    if (n_last == '0)
                    begin
                        // A lone vertex spans itself with no edge.
                        res_next   = '{edge_valid: 1'b0, vertex_a: '0, vertex_b: '0,
                                       chosen_cost: '0, total_cost: '0,
                                       spanning: 1'b1, last: 1'b1};
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        i_next     = '0;
                        addr_next  = '0;
                        best_next  = NO_EDGE;
                        found_next = 1'b0;
                        state_next = ST_ROW;
                    end
                end
                else
                begin
                    j_next = j_reg + VTX_W'(1);
                end
            end
            ST_ROW:
            begin
                lbl_raddr  = i_reg;
                pk_next    = P_HEAD;
                j_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                mat_raddr = addr_reg;
                lbl_raddr = j_reg;
                pk_next   = P_ELEM;
                addr_next = addr_reg + ADDR_W'(1);
                if (j_end)
                begin
                    if (i_end)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next     = i_reg + VTX_W'(1);
                        state_next = ST_ROW;
                    end
                end
                else
                begin
                    j_next = j_reg + VTX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (found_reg)
                begin
                    state_next = ST_MARK_A;
                end
                else
                begin
                    res_next   = '{edge_valid: 1'b0, vertex_a: '0, vertex_b: '0,
                                   chosen_cost: '0, total_cost: sum_reg,
                                   spanning: 1'b0, last: 1'b1};
                    state_next = ST_EMIT;
                end
            end
            ST_MARK_A:
            begin
                mat_we     = 1'b1;
                mat_waddr  = baddr_reg;
                mat_wdata  = NO_EDGE;
                sum_next   = sum_reg + SUM_W'(best_reg);
                edges_next = edges_reg + CNT_W'(1);
                state_next = ST_MARK_B;
            end
            ST_MARK_B:
            begin
                mat_we     = 1'b1;
                mat_waddr  = mirror_wide[ADDR_W-1:0];
                mat_wdata  = NO_EDGE;
                j_next     = '0;
                state_next = ST_RELABEL;
            end
            ST_RELABEL:
            begin
                lbl_raddr = j_reg;
                pk_next   = P_RELAB;
                if (j_end)
                begin
                    state_next = ST_RDRAIN;
                end
                else
                begin
                    j_next = j_reg + VTX_W'(1);
                end
            end
            ST_RDRAIN:
            begin
                res_next   = '{edge_valid: 1'b1, vertex_a: VFIELD_W'(ba_reg),
                               vertex_b: VFIELD_W'(bb_reg),
                               chosen_cost: best_reg[CHOSEN_W-1:0],
                               total_cost: sum_reg, spanning: fin, last: fin};
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                emit_valid = 1'b1;
                if (emit_ready)
                begin
                    if (res_reg.last)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = '0;
                        addr_next  = '0;
                        best_next  = NO_EDGE;
                        found_next = 1'b0;
                        state_next = ST_ROW;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

/* hdl/kruskal_mst_matrix.sv */
// ----------------------------------------------------------------------------
// kruskal_mst_matrix
// Minimum spanning tree by Kruskal's method over a loaded cost matrix.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  cfg      in         vertex_count, always ready
//  cost     in         edge_cost, one matrix entry per item, row-major
//  result   out        edge_valid, vertex_a/b, chosen_cost, total_cost,
//                      spanning, last
//
// Loading takes one item per cycle. The item that completes the matrix starts
// a run: the labels are set up one vertex at a time, then each pass scans the
// matrix through the single read port of its memory (one entry a cycle in a row).
// Cost items are refused while a run is going; a stalled result holds the run.
// Reset clears control state only; the matrix holds no reset values.
module kruskal_mst_matrix (
    input  logic          clk,
    input  logic          rst_n,
    kmm_cfg_if.sink       cfg,
    kmm_cost_if.sink      cost,
    kmm_result_if.source  result
);
    import kmm_pkg::*;

    logic [CFG_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0] n_eff;
    logic             out_valid_reg;
    res_t             out_res_reg;
    logic             emit_valid;
    logic             emit_ready;
    res_t             emit_res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= CFG_W'(16);
        end
        else if (cfg.valid)
        begin
            vertex_count_reg <= cfg.vertex_count;
        end
    end

    // Counts out of range are clamped to the supported span.
    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(vertex_count_reg) > VTX_LIMIT)
        begin
            n_eff = CNT_W'(VTX_LIMIT);
        end
        else
        begin
            n_eff = CNT_W'(vertex_count_reg);
        end
    end

    kmm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .n          (n_eff),
        .in_valid   (cost.valid),
        .in_cost    (cost.edge_cost),
        .in_ready   (cost.ready),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_res   (emit_res)
    );

    assign emit_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_ready)
        begin
            out_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ready && emit_valid)
        begin
            out_res_reg <= emit_res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.edge_valid  = out_res_reg.edge_valid;
    assign result.vertex_a    = out_res_reg.vertex_a;
    assign result.vertex_b    = out_res_reg.vertex_b;
    assign result.chosen_cost = out_res_reg.chosen_cost;
    assign result.total_cost  = out_res_reg.total_cost;
    assign result.spanning    = out_res_reg.spanning;
    assign result.last        = out_res_reg.last;

endmodule
